### src/iidl_pkg.sv
// ----------------------------------------------------------------------------
// iidl_pkg
// Types, codes and sizes shared by the indexed insert/delete list
// ----------------------------------------------------------------------------
package iidl_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned DataW    = 32;
  localparam int unsigned PosW     = 6;
  localparam int unsigned OutCntW  = 7;
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW     = (CntW > PosW) ? CntW : PosW;

  typedef enum logic [2:0] {
    ACT_APPEND      = 3'd0,
    ACT_INSERT      = 3'd1,
    ACT_REMOVE_LAST = 3'd2,
    ACT_REMOVE_AT   = 3'd3,
    ACT_READ        = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN
  } cell_op_e;

  typedef struct packed {
    logic [2:0]              action;
    logic signed [DataW-1:0] value;
    logic [PosW-1:0]         position;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] read_value;
    logic [OutCntW-1:0]      count;
    logic [1:0]              status;
  } out_item_t;

  typedef struct packed {
    cell_op_e          op;
    logic [CmpW-1:0]   pos;
    logic [DataW-1:0]  value;
  } cell_ctrl_t;

endpackage

### src/indexed_insert_delete_list.sv
// ----------------------------------------------------------------------------
// indexed_insert_delete_list
// Ordered list of signed words with append, insert, remove and read
// ----------------------------------------------------------------------------
// Input channel in_valid_i/in_ready_o carries one item: an action, a word
// and a position. Output channel out_valid_o/out_ready_i returns one item
// per input item with the word read, the count after the action and a
// status (ok, full, empty, bad position).
// The result sits in the output register the cycle after the item is taken.
// Throughput is one item per cycle while the receiver takes results, set
// by the row of cells, where every cell picks its own word, its neighbour's
// word or the new word at once, so any shift ends as the cells are clocked.
// The output register frees as it is taken, so a new item is taken in the
// same cycle the waiting result leaves. When the receiver stalls, the
// result holds and in_ready_o drops until it is taken.
// Reset empties the list (count zero) and clears the output valid; the
// stored words keep no reset and are only read below the count.
// ----------------------------------------------------------------------------
module indexed_insert_delete_list import iidl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic [CntW-1:0]  cnt_q;
  logic [CntW-1:0]  cnt_d;
  logic             out_valid_q;
  out_item_t        out_q;
  out_item_t        res;
  cell_ctrl_t       ctrl;
  logic [DataW-1:0] rd_word;
  logic             in_fire;
  logic             full;
  logic             empty;
  logic             bad_pos;
  logic [CmpW-1:0]  pos_ext;
  logic [CmpW-1:0]  cnt_ext;
  status_e          status;
  cell_op_e         op;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign pos_ext = CmpW'(in_item_i.position);
  assign cnt_ext = CmpW'(cnt_q);
  assign full    = (cnt_q == CntW'(CAPACITY));
  assign empty   = (cnt_q == '0);
  assign bad_pos = (pos_ext >= cnt_ext);

  always_comb begin
    status     = ST_OK;
    op         = CELL_HOLD;
    cnt_d      = cnt_q;
    ctrl.pos   = pos_ext;
    ctrl.value = in_item_i.value;
    res        = '0;
    case (action_e'(in_item_i.action))
      ACT_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          op       = CELL_SHIFT_UP;
          ctrl.pos = cnt_ext;
          cnt_d    = CntW'(cnt_q + 1'b1);
        end
      end
      ACT_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else if (bad_pos) begin
          status = ST_BADPOS;
        end else begin
          op    = CELL_SHIFT_UP;
          cnt_d = CntW'(cnt_q + 1'b1);
        end
      end
      ACT_REMOVE_LAST: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          cnt_d = CntW'(cnt_q - 1'b1);
        end
      end
      ACT_REMOVE_AT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (bad_pos) begin
          status = ST_BADPOS;
        end else begin
          op    = CELL_SHIFT_DOWN;
          cnt_d = CntW'(cnt_q - 1'b1);
        end
      end
      ACT_READ: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (bad_pos) begin
          status = ST_BADPOS;
        end else begin
          res.read_value = rd_word;
        end
      end
      default: status = ST_OK;
    endcase
    ctrl.op    = in_fire ? op : CELL_HOLD;
    res.count  = OutCntW'(cnt_d);
    res.status = status;
  end

  iidl_row u_row (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .rd_word_o (rd_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### src/iidl_cell.sv
// ----------------------------------------------------------------------------
// iidl_cell
// One list slot: holds a word, shifts with its neighbours, offers it on read
// ----------------------------------------------------------------------------
module iidl_cell import iidl_pkg::*; (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [CmpW-1:0]  idx_i,
  input  logic [DataW-1:0] left_i,
  input  logic [DataW-1:0] right_i,
  output logic [DataW-1:0] word_o,
  output logic [DataW-1:0] rd_o
);

  logic [DataW-1:0] word_q;
  logic [DataW-1:0] word_d;

  always_comb begin
    word_d = word_q;
    case (ctrl_i.op)
      CELL_SHIFT_UP: begin
        if (idx_i > ctrl_i.pos) begin
          word_d = left_i;
        end else if (idx_i == ctrl_i.pos) begin
          word_d = ctrl_i.value;
        end
      end
      CELL_SHIFT_DOWN: begin
        if (idx_i >= ctrl_i.pos) begin
          word_d = right_i;
        end
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  assign rd_o   = (idx_i == ctrl_i.pos) ? word_q : '0;

endmodule

### src/iidl_row.sv
// ----------------------------------------------------------------------------
// iidl_row
// Chain of list cells with neighbour links and the read-out merge
// ----------------------------------------------------------------------------
module iidl_row import iidl_pkg::*; (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  output logic [DataW-1:0] rd_word_o
);

  logic [DataW-1:0] word  [CAPACITY];
  logic [DataW-1:0] rd    [CAPACITY];
  logic [DataW-1:0] left  [CAPACITY];
  logic [DataW-1:0] right [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left[i] = '0;
    end else begin : g_mid_l
      assign left[i] = word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right[i] = word[i];
    end else begin : g_mid_r
      assign right[i] = word[i+1];
    end

    iidl_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .idx_i   (CmpW'(i)),
      .left_i  (left[i]),
      .right_i (right[i]),
      .word_o  (word[i]),
      .rd_o    (rd[i])
    );
  end

  always_comb begin
    rd_word_o = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      rd_word_o = rd_word_o | rd[i];
    end
  end

endmodule

### src/iidl_checker.sv
// ----------------------------------------------------------------------------
// iidl_checker
// Port-level checks for the indexed insert/delete list
// ----------------------------------------------------------------------------
module iidl_checker import iidl_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("result item changed while stalled");

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input not ready with output register free");

  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ST_OK |-> out_item_o.read_value == '0)
    else $error("failed action returned a nonzero word");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == ST_FULL |->
      out_item_o.count == OutCntW'(CAPACITY))
    else $error("full status with count below capacity");

endmodule

bind indexed_insert_delete_list iidl_checker u_iidl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

### test/indexed_insert_delete_list_test.sv
// ----------------------------------------------------------------------------
// indexed_insert_delete_list_test
// Self-checking bench for the indexed insert/delete list
// ----------------------------------------------------------------------------
// A short directed run covers the empty, bad-position and spare-action cases
// and the word extremes. Random items then swing the list between empty and
// full, with positions mostly inside the list. A model of the list, updated
// as each item is taken, predicts every result, and each result is compared
// field by field. Runs with no idling, a sender that idles, a receiver that
// stalls, and both. One long receiver hold makes the block stall its input.
// ----------------------------------------------------------------------------
module indexed_insert_delete_list_test;
  import iidl_pkg::*;

  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
  localparam int         RANDOM_PER_RUN  = 406;
  localparam int         LONG_HOLD       = 200;
  localparam int         QUIET_LIMIT     = 2000;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item     = '0;
  logic      out_valid_o;
  logic      out_ready   = 1'b0;
  out_item_t out_item_o;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];

  logic signed [DataW-1:0] list_words [CAPACITY];
  int unsigned             list_len = 0;
  int                      gen_len = 0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int holds_served   = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  int mismatch_count = 0;

  indexed_insert_delete_list DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // list model, advanced once per item taken
  function automatic out_item_t apply_list_op(in_item_t it);
    out_item_t   res;
    int unsigned idx;
    res.read_value = '0;
    res.status = ST_OK;
    case (it.action)
      ACT_APPEND, ACT_INSERT: begin
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (it.action == ACT_INSERT && it.position >= list_len) begin
          res.status = ST_BADPOS;
        end else if (it.action == ACT_INSERT) begin
          for (idx = list_len; idx > it.position; idx--)
            list_words[idx] = list_words[idx-1];
          list_words[it.position] = it.value;
          list_len++;
        end else begin
          list_words[list_len] = it.value;
          list_len++;
        end
      end
      ACT_REMOVE_LAST: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else list_len--;
      end
      ACT_REMOVE_AT, ACT_READ: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (it.position >= list_len) begin
          res.status = ST_BADPOS;
        end else if (it.action == ACT_READ) begin
          res.read_value = list_words[it.position];
        end else begin
          for (idx = it.position; idx + 1 < list_len; idx++)
            list_words[idx] = list_words[idx+1];
          list_len--;
        end
      end
      default: ;
    endcase
    res.count = list_len[OutCntW-1:0];
    return res;
  endfunction

  // queues an item and keeps the generator's view of the list length
  task automatic queue_item(logic [2:0] act, logic signed [DataW-1:0] word, int pos);
    in_item_t it;
    it.action = act;
    it.value = word;
    it.position = pos[PosW-1:0];
    pending_items.push_back(it);
    case (act)
      ACT_APPEND: if (gen_len < CAPACITY) gen_len++;
      ACT_INSERT: if (gen_len < CAPACITY && pos < gen_len) gen_len++;
      ACT_REMOVE_LAST: if (gen_len > 0) gen_len--;
      ACT_REMOVE_AT: if (gen_len > 0 && pos < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  function automatic logic signed [DataW-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_position();
    int r;
    r = $urandom_range(0, 9);
    if (gen_len > 0 && r < 8) return $urandom_range(0, gen_len - 1);
    if (r == 8 && gen_len < CAPACITY) return gen_len;
    return $urandom_range(0, 63);
  endfunction

  function automatic logic [2:0] pick_action(bit growing);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    if (r < 20) return ACT_READ;
    if (growing) begin
      if (r < 55) return ACT_APPEND;
      if (r < 85) return ACT_INSERT;
      if (r < 92) return ACT_REMOVE_LAST;
      return ACT_REMOVE_AT;
    end
    if (r < 55) return ACT_REMOVE_AT;
    if (r < 85) return ACT_REMOVE_LAST;
    if (r < 92) return ACT_APPEND;
    return ACT_INSERT;
  endfunction

  task automatic queue_random(int n);
    bit growing;
    growing = 1'b1;
    repeat (n) begin
      if (gen_len >= CAPACITY) growing = 1'b0;
      else if (gen_len == 0) growing = 1'b1;
      else if ($urandom_range(0, 49) == 0) growing = ~growing;
      queue_item(pick_action(growing), pick_word(), pick_position());
    end
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o)
        expected_results.push_back(apply_list_op(in_item));
      if (!in_valid || in_ready_o) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_item  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_requests != holds_served) begin
      holds_served <= holds_served + 1;
      hold_left    <= LONG_HOLD;
      out_ready    <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, read_value %0d count %0d status %0d",
                 $time, out_item_o.read_value, out_item_o.count, out_item_o.status);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_item_o.read_value !== want.read_value) begin
          $display("%0t: read_value expected %0d actual %0d",
                   $time, want.read_value, out_item_o.read_value);
          mismatch_count++;
        end
        if (out_item_o.count !== want.count) begin
          $display("%0t: count expected %0d actual %0d", $time, want.count, out_item_o.count);
          mismatch_count++;
        end
        if (out_item_o.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, want.status, out_item_o.status);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty list, spare actions, extremes, boundary positions
    queue_item(ACT_REMOVE_LAST, 32'sd1, 0);
    queue_item(ACT_REMOVE_AT, 32'sd2, 5);
    queue_item(ACT_READ, 32'sd3, 63);
    queue_item(ACT_INSERT, 32'sd4, 0);
    queue_item(ACT_SPARE_FIRST, 32'sh7fffffff, 63);
    queue_item(ACT_SPARE_LAST, 32'sh80000000, 0);
    queue_item(ACT_APPEND, 32'sh7fffffff, 63);
    queue_item(ACT_APPEND, 32'sh80000000, 0);
    queue_item(ACT_APPEND, -32'sd1, 0);
    queue_item(ACT_INSERT, 32'sd0, 0);
    queue_item(ACT_INSERT, 32'sd12345, 2);
    queue_item(ACT_INSERT, 32'sd99, 5);
    queue_item(ACT_INSERT, 32'sd98, 63);
    queue_item(ACT_READ, 32'sd0, 0);
    queue_item(ACT_READ, 32'sd0, 4);
    queue_item(ACT_READ, 32'sd0, 5);
    queue_item(ACT_READ, 32'sd0, 63);
    queue_item(ACT_REMOVE_AT, 32'sd0, 4);
    queue_item(ACT_REMOVE_AT, 32'sd0, 0);
    queue_item(ACT_REMOVE_AT, 32'sd0, 63);
    queue_item(ACT_READ, 32'sd0, 1);
    queue_item(ACT_REMOVE_LAST, 32'sd0, 0);
    queue_item(ACT_READ, 32'sd0, 0);
    drain();

    // no idling, with one long receiver hold while items keep coming
    hold_requests++;
    queue_random(RANDOM_PER_RUN);
    drain();

    send_idle_pct = 64;
    queue_random(RANDOM_PER_RUN);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 64;
    queue_random(RANDOM_PER_RUN);
    drain();

    send_idle_pct  = 6;
    recv_stall_pct = 6;
    queue_random(RANDOM_PER_RUN);
    drain();

    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
